@@ src/gn3_pkg.sv @@
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared opcodes and types for the 3D gradient noise sampler.
// ----------------------------------------------------------------------------
package gn3_pkg;

	localparam int HASH_W = 8;

	typedef logic [HASH_W-1:0] hash_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

endpackage

@@ src/gn3_ram.sv @@
// ----------------------------------------------------------------------------
// gn3_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gn3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while en is low
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ src/gradient_noise_3d.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Fixed-point improved gradient noise sampler in three dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): opcode OP_LOAD writes entry_value into
//   permutation slot entry_index and produces no output; opcode OP_SAMPLE
//   samples noise at (pos_x, pos_y, pos_z), signed with FRAC_BITS fraction bits.
//   Output channel (out_valid / out_stall): one noise_value (signed Q1.16,
//   saturated) per sample, in input order.
//   A sample passes pipeline stages s1 to s8 and the output register in turn.
//   Throughput: one transaction per cycle while out_stall holds no pending result, loads and samples mixed freely.
//   The table is held in 14 copies (2, 4 and 8 for the three hash levels),
//   each a single-port RAM that serves one read or one write per cycle; a
//   load travels down the pipeline and writes each level's copies in the
//   same stage where samples read them, so accesses stay in order.
//   Every slot must be loaded before a sample hashes to it.
//   Reset clears all pipeline and output valid flags; table contents stay
//   undefined. When out_stall holds a pending result the whole pipeline
//   freezes and in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module gradient_noise_3d #(
	parameter int TABLE_ENTRIES = 256,
	parameter int FRAC_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] noise_value
);

	localparam int F   = FRAC_BITS;
	localparam int AW  = $clog2(TABLE_ENTRIES);
	localparam int G   = F + 3;          // gradient / lerp width
	localparam int M   = 2 * F + 8;      // fade product width
	localparam int LW  = G + F + 3;      // lerp / scale product width
	localparam int SHR = (F > 16) ? F - 16 : 0;
	localparam int SHL = (F < 16) ? 16 - F : 0;
	localparam int OW  = G + 9;

	localparam logic signed [M-1:0] ONE_M  = M'(1) << F;
	localparam logic signed [M-1:0] HALF_M = M'(1) << (F - 1);
	localparam logic signed [M-1:0] SIX_M  = M'(6);
	localparam logic signed [M-1:0] L15_M  = M'(15) << F;
	localparam logic signed [M-1:0] L10_M  = M'(10) << F;
	localparam logic signed [LW-1:0] HALF_L = LW'(1) << (F - 1);
	localparam longint SCALE_K = (longint'(11547) * (longint'(1) << F) + 5000) / 10000;
	localparam logic signed [LW-1:0] SCALE_L = LW'(SCALE_K);
	localparam logic signed [F+1:0] ONE_O = (F + 2)'(1) << F;
	localparam logic signed [OW-1:0] RND_O =
		(SHR > 0) ? (OW'(1) << ((SHR > 0) ? SHR - 1 : 0)) : '0;
	localparam logic signed [OW-1:0] OUT_MAX = OW'(131071);
	localparam logic signed [OW-1:0] OUT_MIN = -OW'(131072);

	function automatic logic [AW-1:0] to_idx(input gn3_pkg::hash_t v);
		logic [AW+7:0] e;
		e = {{AW{1'b0}}, v};
		return e[AW-1:0];
	endfunction

	function automatic logic signed [G-1:0] grad(input logic [3:0] h,
			input logic signed [F+1:0] x, input logic signed [F+1:0] y,
			input logic signed [F+1:0] z);
		logic signed [G-1:0] xg, yg, zg, r;
		xg = G'(x);
		yg = G'(y);
		zg = G'(z);
		case (h)
			4'd0, 4'd12: r = xg + yg;
			4'd1, 4'd14: r = -xg + yg;
			4'd2:        r = xg - yg;
			4'd3:        r = -xg - yg;
			4'd4:        r = xg + zg;
			4'd5:        r = -xg + zg;
			4'd6:        r = xg - zg;
			4'd7:        r = -xg - zg;
			4'd8:        r = yg + zg;
			4'd9, 4'd13: r = -yg + zg;
			4'd10:       r = yg - zg;
			default:     r = -yg - zg;
		endcase
		return r;
	endfunction

	function automatic logic signed [G-1:0] lerp(input logic signed [G-1:0] a,
			input logic signed [G-1:0] b, input logic [F:0] f);
		logic signed [G:0]    d;
		logic signed [LW-1:0] p;
		logic signed [LW-1:0] fs;
		d  = (G + 1)'(b) - (G + 1)'(a);
		fs = $signed(LW'(f));
		p  = (LW'(d) * fs + HALF_L) >>> F;
		return a + p[G-1:0];
	endfunction

	// ---------------- handshake ----------------
	logic adv, accept;
	logic out_valid_q;
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign out_valid = out_valid_q;

	// ---------------- input split ----------------
	logic signed [31+AW:0] pe [3];
	logic [AW-1:0] cell_in [3];
	assign pe[0] = {{AW{pos_x[31]}}, pos_x};
	assign pe[1] = {{AW{pos_y[31]}}, pos_y};
	assign pe[2] = {{AW{pos_z[31]}}, pos_z};
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cell_in[k] = pe[k][F+AW-1:F];
		end
	end

	// ---------------- pipeline registers ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic op_s1, op_s2, op_s3;
	logic [AW-1:0] idx_s1, idx_s2;
	logic [7:0] val_s1, val_s2;
	logic [AW-1:0] c1_s1, c2_s1, c2_s2;
	logic [F-1:0] t_s1 [3];
	logic [F-1:0] t_s2 [3];
	logic [F-1:0] t_s3 [3];
	logic signed [F+4:0] inner_s2 [3];
	logic signed [F+4:0] inner_s3 [3];
	logic signed [F+1:0] tt_s2 [3];
	logic signed [F+1:0] ttt_s3 [3];
	logic [F:0] w_s4 [3];
	logic [F:0] w_s5 [2];
	logic [F:0] w_s6;
	logic signed [G-1:0] g_s4 [8];
	logic signed [G-1:0] e_s5 [4];
	logic signed [G-1:0] e_s6 [2];
	logic signed [G-1:0] r_s7;
	logic signed [G-1:0] sc_s8;
	logic signed [17:0] noise_q;

	// ---------------- table copies ----------------
	gn3_pkg::hash_t l1_q [2];
	gn3_pkg::hash_t l2_q [4];
	gn3_pkg::hash_t l3_q [8];

	genvar gx, gy, gz;
	generate
		for (gx = 0; gx < 2; gx++) begin : g_l1
			logic [AW-1:0] a1;
			assign a1 = (opcode == gn3_pkg::OP_LOAD) ? to_idx(entry_index)
				: cell_in[0] + AW'(gx);
			gn3_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
				.clk(clk), .en(accept), .we(opcode == gn3_pkg::OP_LOAD),
				.addr(a1), .wdata(entry_value), .rdata(l1_q[gx])
			);
			for (gy = 0; gy < 2; gy++) begin : g_l2
				logic [AW-1:0] a2;
				assign a2 = (op_s1 == gn3_pkg::OP_LOAD) ? idx_s1
					: to_idx(l1_q[gx]) + c1_s1 + AW'(gy);
				gn3_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
					.clk(clk), .en(v_s1 && adv), .we(op_s1 == gn3_pkg::OP_LOAD),
					.addr(a2), .wdata(val_s1), .rdata(l2_q[gx*2+gy])
				);
				for (gz = 0; gz < 2; gz++) begin : g_l3
					logic [AW-1:0] a3;
					assign a3 = (op_s2 == gn3_pkg::OP_LOAD) ? idx_s2
						: to_idx(l2_q[gx*2+gy]) + c2_s2 + AW'(gz);
					gn3_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram (
						.clk(clk), .en(v_s2 && adv),
						.we(op_s2 == gn3_pkg::OP_LOAD),
						.addr(a3), .wdata(val_s2), .rdata(l3_q[gx*4+gy*2+gz])
					);
				end
			end
		end
	endgenerate

	// ---------------- fade, stage 1..3 ----------------
	logic signed [M-1:0] tw1 [3];
	logic signed [M-1:0] lin1 [3];
	logic signed [M-1:0] inner1 [3];
	logic signed [M-1:0] tt1 [3];
	logic signed [M-1:0] ttt2 [3];
	logic signed [M-1:0] f3 [3];
	logic [F:0] w3 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tw1[k]    = $signed(M'(t_s1[k]));
			lin1[k]   = SIX_M * tw1[k] - L15_M;
			inner1[k] = ((tw1[k] * lin1[k] + HALF_M) >>> F) + L10_M;
			tt1[k]    = (tw1[k] * tw1[k] + HALF_M) >>> F;
			ttt2[k]   = (M'(tt_s2[k]) * $signed(M'(t_s2[k])) + HALF_M) >>> F;
			f3[k]     = (M'(ttt_s3[k]) * M'(inner_s3[k]) + HALF_M) >>> F;
			if (f3[k] < 0) begin
				w3[k] = '0;
			end else if (f3[k] > ONE_M) begin
				w3[k] = ONE_M[F:0];
			end else begin
				w3[k] = f3[k][F:0];
			end
		end
	end

	// ---------------- gradients, stage 3 ----------------
	logic signed [F+1:0] off [3][2];
	logic signed [G-1:0] g3 [8];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			off[k][0] = $signed({2'b00, t_s3[k]});
			off[k][1] = $signed({2'b00, t_s3[k]}) - ONE_O;
		end
		for (int c = 0; c < 8; c++) begin
			g3[c] = grad(l3_q[c][3:0], off[0][c/4], off[1][(c/2)%2], off[2][c%2]);
		end
	end

	// ---------------- scale and output conversion ----------------
	logic signed [LW-1:0] sc7;
	logic signed [OW-1:0] o8;
	logic signed [17:0]   sat8;
	always_comb begin
		sc7 = (LW'(r_s7) * SCALE_L + HALF_L) >>> F;
		o8  = ((OW'(sc_s8) + RND_O) >>> SHR) <<< SHL;
		if (o8 > OUT_MAX) begin
			sat8 = OUT_MAX[17:0];
		end else if (o8 < OUT_MIN) begin
			sat8 = OUT_MIN[17:0];
		end else begin
			sat8 = o8[17:0];
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && (op_s3 == gn3_pkg::OP_SAMPLE);
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			out_valid_q <= v_s8;
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= opcode;
			idx_s1 <= to_idx(entry_index);
			val_s1 <= entry_value;
			c1_s1  <= cell_in[1];
			c2_s1  <= cell_in[2];
			t_s1[0] <= pos_x[F-1:0];
			t_s1[1] <= pos_y[F-1:0];
			t_s1[2] <= pos_z[F-1:0];

			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			c2_s2  <= c2_s1;
			op_s3  <= op_s2;
			for (int k = 0; k < 3; k++) begin
				t_s2[k]     <= t_s1[k];
				t_s3[k]     <= t_s2[k];
				inner_s2[k] <= inner1[k][F+4:0];
				tt_s2[k]    <= tt1[k][F+1:0];
				inner_s3[k] <= inner_s2[k];
				ttt_s3[k]   <= ttt2[k][F+1:0];
				w_s4[k]     <= w3[k];
			end

			for (int c = 0; c < 8; c++) begin
				g_s4[c] <= g3[c];
			end
			// x blend: corners differing only in x
			for (int j = 0; j < 4; j++) begin
				e_s5[j] <= lerp(g_s4[j], g_s4[j+4], w_s4[0]);
			end
			w_s5[0] <= w_s4[1];
			w_s5[1] <= w_s4[2];
			// y blend, index j = y*2 + z
			for (int z = 0; z < 2; z++) begin
				e_s6[z] <= lerp(e_s5[z], e_s5[z+2], w_s5[0]);
			end
			w_s6  <= w_s5[1];
			r_s7  <= lerp(e_s6[0], e_s6[1], w_s6);
			sc_s8 <= sc7[G-1:0];
			if (v_s8) begin
				noise_q <= sat8;
			end
		end
	end

	assign noise_value = noise_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks gradient_noise_3d: loads the permutation table, then drives directed
// and random samples and table reloads with random gaps and output stalls.
// A fixed-point noise predictor in the scoreboard checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int  CYCLE_LIMIT = 300000;
	localparam int  PIPE_DRAIN  = 20;
	localparam int  N_RANDOM    = 430;
	localparam longint FONE     = 64'sd65536;
	localparam longint SCALE_K  = (64'sd11547 * FONE + 64'sd5000) / 64'sd10000;

	class noise_scoreboard;
		gn3_pkg::hash_t           perm [256];
		logic signed [17:0]       expected_q [$];
		int                       mismatches;

		function longint mulq(longint a, longint b);
			return (a * b + 64'sd32768) >>> 16;
		endfunction

		function longint fade(longint t);
			longint inner, f;
			inner = mulq(t, 6 * t - 15 * FONE) + 10 * FONE;
			f = mulq(mulq(mulq(t, t), t), inner);
			if (f < 0) f = 0;
			if (f > FONE) f = FONE;
			return f;
		endfunction

		function longint lerp(longint a, longint b, longint f);
			return a + mulq(b - a, f);
		endfunction

		function longint grad(gn3_pkg::hash_t h, longint x, longint y, longint z);
			case (h[3:0])
				4'd0, 4'd12: return x + y;
				4'd1, 4'd14: return -x + y;
				4'd2:        return x - y;
				4'd3:        return -x - y;
				4'd4:        return x + z;
				4'd5:        return -x + z;
				4'd6:        return x - z;
				4'd7:        return -x - z;
				4'd8:        return y + z;
				4'd9, 4'd13: return -y + z;
				4'd10:       return y - z;
				default:     return -y - z;
			endcase
		endfunction

		function logic signed [17:0] noise_at(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz);
			gn3_pkg::hash_t cx, cy, cz, a, b, aa, ab, ba, bb;
			longint tx, ty, tz, wx, wy, wz, x1, y1, z1;
			longint e00, e10, e01, e11, r;
			cx = px[23:16]; cy = py[23:16]; cz = pz[23:16];
			tx = longint'(px[15:0]); ty = longint'(py[15:0]); tz = longint'(pz[15:0]);
			wx = fade(tx); wy = fade(ty); wz = fade(tz);
			x1 = tx - FONE; y1 = ty - FONE; z1 = tz - FONE;
			// all index sums wrap in 8 bits
			a  = perm[cx];       b  = perm[gn3_pkg::hash_t'(cx + 1)];
			aa = perm[gn3_pkg::hash_t'(a + cy)]; ab = perm[gn3_pkg::hash_t'(a + cy + 1)];
			ba = perm[gn3_pkg::hash_t'(b + cy)]; bb = perm[gn3_pkg::hash_t'(b + cy + 1)];
			e00 = lerp(grad(perm[gn3_pkg::hash_t'(aa + cz)], tx, ty, tz),
				grad(perm[gn3_pkg::hash_t'(ba + cz)], x1, ty, tz), wx);
			e10 = lerp(grad(perm[gn3_pkg::hash_t'(ab + cz)], tx, y1, tz),
				grad(perm[gn3_pkg::hash_t'(bb + cz)], x1, y1, tz), wx);
			e01 = lerp(grad(perm[gn3_pkg::hash_t'(aa + cz + 1)], tx, ty, z1),
				grad(perm[gn3_pkg::hash_t'(ba + cz + 1)], x1, ty, z1), wx);
			e11 = lerp(grad(perm[gn3_pkg::hash_t'(ab + cz + 1)], tx, y1, z1),
				grad(perm[gn3_pkg::hash_t'(bb + cz + 1)], x1, y1, z1), wx);
			r = mulq(lerp(lerp(e00, e10, wy), lerp(e01, e11, wy), wz), SCALE_K);
			if (r > 131071) r = 131071;
			if (r < -131072) r = -131072;
			return r[17:0];
		endfunction

		function void note_input(logic op, logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz, logic [7:0] idx, logic [7:0] val);
			if (op == gn3_pkg::OP_LOAD)
				perm[idx] = val;
			else
				expected_q.push_back(noise_at(px, py, pz));
		endfunction

		function void check(logic signed [17:0] got);
			logic signed [17:0] want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected noise_value %0d", got);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("noise_value mismatch: expected %0d actual %0d", want, got);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = gn3_pkg::OP_LOAD;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [7:0]         entry_index = '0, entry_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [17:0] noise_value;

	noise_scoreboard sb = new();
	bit  idle_on = 1'b0;
	bit  hold_req = 1'b0;
	int  cycles = 0;

	gradient_noise_3d dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL gradient_noise_3d");
			$finish;
		end
	end

	// result side: check, plus random stall bursts and one long hold-off
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check(noise_value);

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				n = 0;
				while (n < 80) begin
					@(posedge clk);
					n++;
				end
				@(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall <= 1'b0;
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic send(logic op, logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic [7:0] idx, logic [7:0] val);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		pos_x       <= px;
		pos_y       <= py;
		pos_z       <= pz;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, px, py, pz, idx, val);
		@(negedge clk);
	endtask

	task automatic sample(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		send(gn3_pkg::OP_SAMPLE, px, py, pz, 8'($urandom), 8'($urandom));
	endtask

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
			2:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
		endcase
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full table first so no sample reads an unwritten slot
		for (int i = 0; i < 256; i++)
			send(gn3_pkg::OP_LOAD, 32'($urandom), 32'($urandom), 32'($urandom), 8'(i),
				8'($urandom));

		sample(0, 0, 0);
		sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		sample(32'h80000000, 32'h80000000, 32'h80000000);
		sample(32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF);
		sample(32'h00008000, 32'h00008000, 32'h00008000);
		sample(32'hFFFF0000, 32'h00010000, 32'h00FF8000);
		sample(32'hFFFFFFFF, 32'h80000001, 32'h0000C000);
		sample(32'h01000000, 32'h00FF4000, 32'hFF00FFFF);
		sample(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
		// sweep each gradient code through slot zero, reloaded between samples
		for (int g = 0; g < 16; g++) begin
			send(gn3_pkg::OP_LOAD, 0, 0, 0, 8'hFF, 8'h00);
			send(gn3_pkg::OP_LOAD, 0, 0, 0, 8'h00, 8'(g));
			sample(32'h00004000 + g * 32'h1000, 32'h0000A000, 32'h00006000);
		end
		send(gn3_pkg::OP_LOAD, 0, 0, 0, 8'h00, 8'hFF);
		send(gn3_pkg::OP_LOAD, 0, 0, 0, 8'hFF, 8'hA5);

		idle_on = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 100)
				hold_req = 1'b1;
			if (i == 200) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (sb.expected_q.size() != 0) @(negedge clk);
			end
			if (i == 350)
				idle_on = 1'b0;
			if ($urandom_range(0, 9) == 0)
				send(gn3_pkg::OP_LOAD, rand_pos(), rand_pos(), rand_pos(), 8'($urandom),
					8'($urandom));
			else
				sample(rand_pos(), rand_pos(), rand_pos());
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("PASS gradient_noise_3d");
		else
			$display("FAIL gradient_noise_3d");
		$finish;
	end

endmodule
